FILE: hw/rtl/xfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cross-fader package
// Shared constants, command codes, sweep operations and memory word layouts.
// ----------------------------------------------------------------------------
package xfd_pkg;

   // default and largest channel count
   localparam int CHANNELS_DEFAULT = 512;
   localparam int CHANNELS_MAX     = 512;

   // stream widths (bytes filled up with zeros)
   localparam int REQ_DATA_W = 56;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 24;

   // fade timing in milliseconds
   localparam int unsigned FADE_MS  = 500;
   localparam int unsigned FRAME_MS = 25;

   // step = floor(prod / 500) = floor((prod >> 2) / 125), done as a
   // multiply by a rounded-up reciprocal; exact for prod below 127500
   localparam int unsigned FADE_QUARTER = FADE_MS / 4;
   localparam int unsigned RECIP_SHIFT  = 22;
   localparam int unsigned RECIP_MUL    =
      ((32'd1 << RECIP_SHIFT) + FADE_QUARTER - 1) / FADE_QUARTER;

   // input item kinds
   typedef enum logic [1:0] {
      CMD_STAGE  = 2'd0,
      CMD_COMMIT = 2'd1,
      CMD_TICK   = 2'd2,
      CMD_READ   = 2'd3
   } cmd_type;

   // what a sweep does to every channel
   typedef enum logic [1:0] {
      OP_COMMIT_JUMP = 2'd0,
      OP_COMMIT_RAMP = 2'd1,
      OP_TICK_END    = 2'd2,
      OP_TICK_BLEND  = 2'd3
   } sweep_op_type;

   // sweep pipeline control
   typedef struct packed {
      logic         valid;
      sweep_op_type op;
   } sweep_ctl_type;

   // one entry of the level memory
   typedef struct packed {
      logic [7:0] target;
      logic [7:0] start;
      logic [7:0] current;
   } level_word_type;

   // one entry of the staging memory
   typedef struct packed {
      logic       mark;
      logic [7:0] level;
   } staged_word_type;

endpackage

FILE: hw/rtl/dmx_channel_crossfader.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DMX channel cross-fader
// Keeps per-channel current, start and target levels and cross-fades them.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command per transfer: stage a channel level, commit
//   the staged set (jump or 500 ms ramp), a millisecond tick, or a read.
//   rsp_* returns exactly one result per command. csr_* writes the
//   exponential drive mode bit and is always ready.
// Results and throughput:
//   stage and idle commit/tick: result registered in the next cycle.
//   read: result after the level memory read and the ST_READ state.
//   active commit/tick: the update pipeline walks all channels, one per
//   cycle, and the result is loaded on the last write-back; the
//   next command can be taken in the cycle that result is taken.
// Reset:
//   after reset a clearing pass writes zero to every entry of both memories,
//   during which req_tready is low.
// Stalls:
//   a result waits in the output register; a new command is taken only when
//   that register is empty or being emptied in the same cycle.
// ----------------------------------------------------------------------------
module dmx_channel_crossfader #(
   parameter int CHANNELS = xfd_pkg::CHANNELS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   // command stream
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // tdata: channel[8:0], level[16:9], ramp[17], now_ms[49:18], zero fill
   input  logic [xfd_pkg::REQ_DATA_W-1:0] req_tdata,
   // tuser: cmd[1:0]
   input  logic [xfd_pkg::REQ_USER_W-1:0] req_tuser,
   // result stream
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // tdata: current_level[7:0], drive_level[15:8], frame_due[16],
   //        fading[17], zero fill
   output logic [xfd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // register write
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [0:0]                     csr_data
);

   localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(CHANNELS - 1);
   localparam logic [9:0]    CHAN_LIMIT = 10'(CHANNELS);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SWEEP,
      ST_READ
   } state_type;

   state_type                state_ff;
   logic [AW-1:0]            clr_addr_ff;
   logic [AW-1:0]            issue_addr_ff;
   logic                     issuing_ff;
   xfd_pkg::sweep_op_type    sweep_op_ff;
   logic [8:0]               elapsed_ff;
   xfd_pkg::sweep_ctl_type   rd_ctl_ff;
   logic [AW-1:0]            rd_addr_ff;
   logic                     rd_ok_ff;
   logic                     exponential_ff;
   logic                     fade_active_ff;
   logic [31:0]              fade_start_ff;
   logic [31:0]              last_frame_ff;
   logic                     any_staged_ff;
   logic                     frame_ff;
   logic                     rsp_valid_ff;
   logic [7:0]               rsp_cur_ff;
   logic [7:0]               rsp_drv_ff;
   logic                     rsp_frame_ff;
   logic                     rsp_fade_ff;

   xfd_pkg::cmd_type         req_cmd;
   logic [8:0]               req_channel;
   logic [7:0]               req_level;
   logic                     req_ramp;
   logic [31:0]              req_now;
   logic                     accept;
   logic                     chan_ok;
   logic [31:0]              elapsed;
   logic [31:0]              frame_gap;
   logic                     fade_done;
   logic                     gap_due;
   logic                     rsp_load;

   logic                     lvl_wr_en;
   logic [AW-1:0]            lvl_wr_addr;
   xfd_pkg::level_word_type  lvl_wr_data;
   logic                     lvl_rd_en;
   logic [AW-1:0]            lvl_rd_addr;
   xfd_pkg::level_word_type  lvl_rd_data;
   logic                     stg_wr_en;
   logic [AW-1:0]            stg_wr_addr;
   xfd_pkg::staged_word_type stg_wr_data;
   logic                     stg_rd_en;
   xfd_pkg::staged_word_type stg_rd_data;

   xfd_pkg::sweep_ctl_type   blend_ctl;
   logic [AW-1:0]            blend_addr;
   xfd_pkg::level_word_type  blend_word;
   logic                     sweep_last;
   logic                     commit_op;

   logic [15:0]              square;
   logic [16:0]              drv_sum;
   logic [7:0]               drive;

   // unpack the command transfer
   assign req_cmd     = xfd_pkg::cmd_type'(req_tuser);
   assign req_channel = req_tdata[8:0];
   assign req_level   = req_tdata[16:9];
   assign req_ramp    = req_tdata[17];
   assign req_now     = req_tdata[49:18];

   // handshake
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // timing compares for commit and tick
   assign chan_ok   = {1'b0, req_channel} < CHAN_LIMIT;
   assign elapsed   = req_now - fade_start_ff;
   assign frame_gap = req_now - last_frame_ff;
   assign fade_done = elapsed >= 32'(xfd_pkg::FADE_MS);
   assign gap_due   = frame_gap >= 32'(xfd_pkg::FRAME_MS);

   // end of a sweep: last channel written back
   assign commit_op  = sweep_op_ff inside {xfd_pkg::OP_COMMIT_JUMP, xfd_pkg::OP_COMMIT_RAMP};
   assign sweep_last = blend_ctl.valid && (blend_addr == LAST_ADDR);

   // load a result for every command that finishes in this cycle
   always_comb begin
      rsp_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_load = (req_cmd == xfd_pkg::CMD_STAGE) ||
                          (req_cmd == xfd_pkg::CMD_COMMIT && !any_staged_ff) ||
                          (req_cmd == xfd_pkg::CMD_TICK && !fade_active_ff);
            end
         end
         ST_SWEEP: rsp_load = sweep_last;
         ST_READ:  rsp_load = 1'b1;
         default:  rsp_load = 1'b0;
      endcase
   end

   // level memory ports
   always_comb begin
      lvl_rd_en   = (state_ff == ST_SWEEP && issuing_ff) ||
                    (accept && req_cmd == xfd_pkg::CMD_READ);
      lvl_rd_addr = (state_ff == ST_SWEEP) ? issue_addr_ff : req_channel[AW-1:0];
      lvl_wr_en   = (state_ff == ST_CLEAR) || blend_ctl.valid;
      lvl_wr_addr = (state_ff == ST_CLEAR) ? clr_addr_ff : blend_addr;
      lvl_wr_data = (state_ff == ST_CLEAR) ? '0 : blend_word;
   end

   // staging memory ports
   always_comb begin
      stg_rd_en   = (state_ff == ST_SWEEP) && issuing_ff;
      stg_wr_en   = 1'b0;
      stg_wr_addr = blend_addr;
      stg_wr_data = '0;
      if (state_ff == ST_CLEAR) begin
         stg_wr_en   = 1'b1;
         stg_wr_addr = clr_addr_ff;
      end else if (accept && req_cmd == xfd_pkg::CMD_STAGE) begin
         stg_wr_en         = chan_ok;
         stg_wr_addr       = req_channel[AW-1:0];
         stg_wr_data.mark  = 1'b1;
         stg_wr_data.level = req_level;
      end else if (blend_ctl.valid && commit_op) begin
         stg_wr_en = 1'b1;
      end
   end

   xfd_ram #(
      .WIDTH ($bits(xfd_pkg::level_word_type)),
      .DEPTH (CHANNELS)
   ) u_level_ram (
      .clock   (clock),
      .wr_en   (lvl_wr_en),
      .wr_addr (lvl_wr_addr),
      .wr_data (lvl_wr_data),
      .rd_en   (lvl_rd_en),
      .rd_addr (lvl_rd_addr),
      .rd_data (lvl_rd_data)
   );

   xfd_ram #(
      .WIDTH ($bits(xfd_pkg::staged_word_type)),
      .DEPTH (CHANNELS)
   ) u_staged_ram (
      .clock   (clock),
      .wr_en   (stg_wr_en),
      .wr_addr (stg_wr_addr),
      .wr_data (stg_wr_data),
      .rd_en   (stg_rd_en),
      .rd_addr (issue_addr_ff),
      .rd_data (stg_rd_data)
   );

   xfd_blend #(
      .AW (AW)
   ) u_blend (
      .clock    (clock),
      .reset    (reset),
      .in_ctl   (rd_ctl_ff),
      .in_addr  (rd_addr_ff),
      .elapsed  (elapsed_ff),
      .lvl_word (lvl_rd_data),
      .stg_word (stg_rd_data),
      .wr_ctl   (blend_ctl),
      .wr_addr  (blend_addr),
      .wr_word  (blend_word)
   );

   // drive level: c*c/255 as (x + (x >> 8) + 1) >> 8
   always_comb begin
      square  = 16'(lvl_rd_data.current * lvl_rd_data.current);
      drv_sum = 17'(square) + 17'(square[15:8]) + 17'd1;
      drive   = exponential_ff ? drv_sum[15:8] : lvl_rd_data.current;
   end

   // control state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clr_addr_ff     <= '0;
         issue_addr_ff   <= '0;
         issuing_ff      <= 1'b0;
         rd_ctl_ff.valid <= 1'b0;
         exponential_ff  <= 1'b0;
         fade_active_ff  <= 1'b0;
         fade_start_ff   <= '0;
         last_frame_ff   <= '0;
         any_staged_ff   <= 1'b0;
         frame_ff        <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_valid) begin
            exponential_ff <= csr_data[0];
         end
         // hold a stalled result, drop it once taken, load a new one
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && !rsp_tready);

         // align the sweep control with the memory read data
         rd_ctl_ff.valid <= (state_ff == ST_SWEEP) && issuing_ff;

         case (state_ff)
            ST_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + 1'b1;
               if (clr_addr_ff == LAST_ADDR) begin
                  state_ff <= ST_IDLE;
               end
            end

            ST_IDLE: begin
               if (accept) begin
                  case (req_cmd)
                     xfd_pkg::CMD_STAGE: begin
                        if (chan_ok) begin
                           any_staged_ff <= 1'b1;
                        end
                        rsp_cur_ff   <= '0;
                        rsp_drv_ff   <= '0;
                        rsp_frame_ff <= 1'b0;
                        rsp_fade_ff  <= fade_active_ff;
                     end
                     xfd_pkg::CMD_COMMIT: begin
                        if (any_staged_ff) begin
                           any_staged_ff <= 1'b0;
                           state_ff      <= ST_SWEEP;
                           issue_addr_ff <= '0;
                           issuing_ff    <= 1'b1;
                           if (!req_ramp) begin
                              sweep_op_ff    <= xfd_pkg::OP_COMMIT_JUMP;
                              fade_active_ff <= 1'b0;
                              frame_ff       <= 1'b1;
                              last_frame_ff  <= req_now;
                           end else begin
                              sweep_op_ff    <= xfd_pkg::OP_COMMIT_RAMP;
                              fade_active_ff <= 1'b1;
                              fade_start_ff  <= req_now;
                              frame_ff       <= 1'b0;
                           end
                        end else begin
                           rsp_cur_ff   <= '0;
                           rsp_drv_ff   <= '0;
                           rsp_frame_ff <= 1'b0;
                           rsp_fade_ff  <= fade_active_ff;
                        end
                     end
                     xfd_pkg::CMD_TICK: begin
                        if (fade_active_ff) begin
                           state_ff      <= ST_SWEEP;
                           issue_addr_ff <= '0;
                           issuing_ff    <= 1'b1;
                           if (fade_done) begin
                              sweep_op_ff    <= xfd_pkg::OP_TICK_END;
                              fade_active_ff <= 1'b0;
                              frame_ff       <= 1'b1;
                              last_frame_ff  <= req_now;
                           end else begin
                              sweep_op_ff <= xfd_pkg::OP_TICK_BLEND;
                              elapsed_ff  <= elapsed[8:0];
                              frame_ff    <= gap_due;
                              if (gap_due) begin
                                 last_frame_ff <= req_now;
                              end
                           end
                        end else begin
                           rsp_cur_ff   <= '0;
                           rsp_drv_ff   <= '0;
                           rsp_frame_ff <= 1'b0;
                           rsp_fade_ff  <= fade_active_ff;
                        end
                     end
                     default: begin
                        state_ff <= ST_READ;
                        rd_ok_ff <= chan_ok;
                     end
                  endcase
               end
            end

            ST_SWEEP: begin
               // issue one channel a cycle, finish on the last write-back
               if (issuing_ff) begin
                  issue_addr_ff <= issue_addr_ff + 1'b1;
                  if (issue_addr_ff == LAST_ADDR) begin
                     issuing_ff <= 1'b0;
                  end
               end
               if (sweep_last) begin
                  state_ff     <= ST_IDLE;
                  rsp_cur_ff   <= '0;
                  rsp_drv_ff   <= '0;
                  rsp_frame_ff <= frame_ff;
                  rsp_fade_ff  <= fade_active_ff;
               end
            end

            ST_READ: begin
               state_ff     <= ST_IDLE;
               rsp_cur_ff   <= rd_ok_ff ? lvl_rd_data.current : 8'd0;
               rsp_drv_ff   <= rd_ok_ff ? drive : 8'd0;
               rsp_frame_ff <= 1'b0;
               rsp_fade_ff  <= fade_active_ff;
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
      rd_ctl_ff.op <= sweep_op_ff;
      rd_addr_ff   <= issue_addr_ff;
   end

   // pack the result transfer
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_fade_ff, rsp_frame_ff, rsp_drv_ff, rsp_cur_ff};

`ifndef SYNTHESIS
   // write-backs from the update pipeline only during a sweep
   assert property (@(posedge clock) disable iff (reset)
      blend_ctl.valid |-> state_ff == ST_SWEEP)
      else $error("channel write-back outside a sweep");

   // the last write-back of a sweep delivers the result
   assert property (@(posedge clock) disable iff (reset)
      sweep_last |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("sweep ended without a result");

   // nothing is taken or returned while the memories are being cleared
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !rsp_valid_ff && !req_tready)
      else $error("activity during the clearing pass");

   // a command is never taken over a result that stays stalled
   assert property (@(posedge clock) disable iff (reset)
      accept |-> !(rsp_valid_ff && !rsp_tready))
      else $error("command taken while a stalled result is held");
`endif

endmodule

FILE: hw/rtl/xfd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module xfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/xfd_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cross-fader channel update pipeline
// Takes one channel's memory words a cycle and produces its new level word:
// commit load, fade end or linear interpolation over the elapsed time.
// ----------------------------------------------------------------------------
module xfd_blend #(
   parameter int AW = 9
) (
   input  logic                     clock,
   input  logic                     reset,
   input  xfd_pkg::sweep_ctl_type   in_ctl,
   input  logic [AW-1:0]            in_addr,
   input  logic [8:0]               elapsed,
   input  xfd_pkg::level_word_type  lvl_word,
   input  xfd_pkg::staged_word_type stg_word,
   output xfd_pkg::sweep_ctl_type   wr_ctl,
   output logic [AW-1:0]            wr_addr,
   output xfd_pkg::level_word_type  wr_word
);

   xfd_pkg::level_word_type word_n;
   logic [7:0]              new_target;
   logic                    rising;
   logic [7:0]              diff;
   logic [16:0]             prod;

   xfd_pkg::sweep_ctl_type  ctl1_ff;
   logic [AW-1:0]           addr1_ff;
   xfd_pkg::level_word_type word1_ff;
   logic                    rise1_ff;
   logic [16:0]             prod1_ff;

   xfd_pkg::sweep_ctl_type  ctl2_ff;
   logic [AW-1:0]           addr2_ff;
   xfd_pkg::level_word_type word2_ff;
   logic                    rise2_ff;
   logic [30:0]             qmul2_ff;

   logic [7:0]              step;
   logic [7:0]              blended;

   // first stage: select new words, form |target - start| * elapsed
   always_comb begin
      new_target = stg_word.mark ? stg_word.level : lvl_word.current;
      word_n     = lvl_word;
      case (in_ctl.op)
         xfd_pkg::OP_COMMIT_JUMP: begin
            word_n.target  = new_target;
            word_n.start   = lvl_word.current;
            word_n.current = new_target;
         end
         xfd_pkg::OP_COMMIT_RAMP: begin
            word_n.target  = new_target;
            word_n.start   = lvl_word.current;
         end
         xfd_pkg::OP_TICK_END: begin
            word_n.current = lvl_word.target;
         end
         default: begin
            word_n = lvl_word;
         end
      endcase
      rising = lvl_word.target >= lvl_word.start;
      diff   = rising ? (lvl_word.target - lvl_word.start)
                      : (lvl_word.start - lvl_word.target);
      prod   = 17'(diff * elapsed);
   end

   // advance the two pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff.valid <= 1'b0;
         ctl2_ff.valid <= 1'b0;
      end else begin
         ctl1_ff.valid <= in_ctl.valid;
         ctl2_ff.valid <= ctl1_ff.valid;
      end
      ctl1_ff.op <= in_ctl.op;
      addr1_ff   <= in_addr;
      word1_ff   <= word_n;
      rise1_ff   <= rising;
      prod1_ff   <= prod;

      ctl2_ff.op <= ctl1_ff.op;
      addr2_ff   <= addr1_ff;
      word2_ff   <= word1_ff;
      rise2_ff   <= rise1_ff;
      qmul2_ff   <= 31'(prod1_ff[16:2] * 16'(xfd_pkg::RECIP_MUL));
   end

   // last stage: apply the truncated step toward the target
   always_comb begin
      step    = qmul2_ff[29:22];
      blended = rise2_ff ? (word2_ff.start + step) : (word2_ff.start - step);
      wr_word = word2_ff;
      if (ctl2_ff.op == xfd_pkg::OP_TICK_BLEND) begin
         wr_word.current = blended;
      end
   end

   assign wr_ctl  = ctl2_ff;
   assign wr_addr = addr2_ff;

endmodule
